/* rtl/wsm_pkg.sv */
// Shared constants, codes and types for the star-only wildcard matcher.
package wsm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CLOSE_LVLS  = $clog2(PATTERN_MAX + 1);

    localparam logic [7:0] STAR_BYTE = 8'h2A;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic step;
        logic finish;
    } cmd_t;

endpackage

/* rtl/wsm_pattern.sv */
// Pattern store, star and occupancy masks, length and sticky overflow flag.
module wsm_pattern
    import wsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [7:0]               symbol,
    output logic [PATTERN_MAX-1:0]   star,
    output logic [PATTERN_MAX-1:0]   hit,
    output logic [LEN_W-1:0]         length,
    output logic                     overflow
);

    logic [7:0]             store_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] used_reg;
    logic [PATTERN_MAX-1:0] star_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   ovf_reg;
    logic                   full;
    logic [IDX_W-1:0]       wr_idx;

    assign full   = (len_reg == LEN_W'(PATTERN_MAX));
    assign wr_idx = len_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            store_reg[wr_idx] <= symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            star_reg <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            used_reg <= '0;
            star_reg <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.append)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                used_reg[wr_idx] <= 1'b1;
                star_reg[wr_idx] <= (symbol == STAR_BYTE);
                len_reg          <= len_reg + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            hit[i] = used_reg[i] && !star_reg[i] && (store_reg[i] == symbol);
        end
    end

    assign star     = star_reg;
    assign length   = len_reg;
    assign overflow = ovf_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow set while store not full");

    a_star_used: assert property (@(posedge clk) disable iff (!rst_n)
        (star_reg & ~used_reg) == '0)
        else $error("star mark on unused position");

endmodule

/* rtl/wsm_nfa.sv */
// Active position vector with star closure and one-step advance per subject byte.
module wsm_nfa
    import wsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [PATTERN_MAX-1:0]   star,
    input  logic [PATTERN_MAX-1:0]   hit,
    input  logic [LEN_W-1:0]         length,
    output logic                     accept
);

    logic [PATTERN_MAX:0] active_reg;
    logic [PATTERN_MAX:0] active_next;
    logic [PATTERN_MAX:0] closed;
    logic [PATTERN_MAX:0] prop;
    logic [PATTERN_MAX:0] restart_vec;

    assign restart_vec = (PATTERN_MAX + 1)'(1);

    // parallel prefix: bit j inherits from j-d across an all-star span
    always_comb
    begin
        closed = active_reg;
        prop   = {star, 1'b0};
        for (int l = 0; l < CLOSE_LVLS; l++)
        begin
            for (int j = PATTERN_MAX; j >= 0; j--)
            begin
                if (j >= (1 << l))
                begin
                    closed[j] = closed[j] | (prop[j] & closed[j - (1 << l)]);
                    prop[j]   = prop[j] & prop[j - (1 << l)];
                end
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        if (cmd.clear || cmd.append || cmd.finish)
        begin
            active_next = restart_vec;
        end
        else if (cmd.step)
        begin
            active_next = ({1'b0, closed[PATTERN_MAX-1:0] & star})
                        | ({closed[PATTERN_MAX-1:0] & hit, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= restart_vec;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign accept = closed[length];

    a_above_len: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg >> length) <= (PATTERN_MAX + 1)'(1))
        else $error("active position beyond pattern length");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear || cmd.append || cmd.finish) |=> active_reg == restart_vec)
        else $error("subject did not restart");

endmodule

/* rtl/wildcard_star_matcher.sv */
// Top level: input register, command decode, result register with stream handshakes.
// Flow: an accepted item is held in the input register and executed from there; the result
// of an end item is written to the result register and offered on the master side.
// Throughput: one item per cycle, any mix of modes; an end item waits in the input
// register only while the previous result has not been taken.
// Reset: asynchronous, active low; pattern empty, overflow clear, position zero active.
module wildcard_star_matcher
    import wsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    logic        in_valid_reg;
    mode_t       mode_reg;
    logic [7:0]  sym_reg;
    logic        out_valid_reg;
    logic        matched_reg;
    logic        overflow_reg;
    logic        exec;
    cmd_t        cmd;

    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] hit;
    logic [LEN_W-1:0]       length;
    logic                   overflow;
    logic                   accept;

    assign exec = in_valid_reg && ((mode_reg != MODE_END) || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec;

    always_comb
    begin
        cmd = '0;
        if (exec)
        begin
            unique case (mode_reg)
                MODE_CLEAR:   cmd.clear  = 1'b1;
                MODE_APPEND:  cmd.append = 1'b1;
                MODE_SUBJECT: cmd.step   = 1'b1;
                MODE_END:     cmd.finish = 1'b1;
                default:      cmd = '0;
            endcase
        end
    end

    wsm_pattern u_pattern (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .symbol   (sym_reg),
        .star     (star),
        .hit      (hit),
        .length   (length),
        .overflow (overflow)
    );

    wsm_nfa u_nfa (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .star   (star),
        .hit    (hit),
        .length (length),
        .accept (accept)
    );

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            mode_reg <= mode_t'(s_axis_tuser);
            sym_reg  <= s_axis_tdata;
        end
        if (cmd.finish)
        begin
            matched_reg  <= accept;
            overflow_reg <= overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, overflow_reg, matched_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.finish && out_valid_reg && !m_axis_tready))
        else $error("result register overwritten before it was taken");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("end item gave no result");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd) && (exec == (cmd != '0)))
        else $error("command decode inconsistent");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for wildcard_star_matcher: directed, overflow and random glob items.
module testbench;
    import wsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    mode_t      s_tuser = MODE_CLEAR;
    logic       m_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;

    // predictor state
    logic [7:0]           pat_mem [0:PATTERN_MAX-1];
    int                   pat_len = 0;
    logic [PATTERN_MAX:0] live = (PATTERN_MAX + 1)'(1);
    logic                 dropped = 1'b0;

    verdict_t verdicts [$];
    int       fails = 0;
    int       items_sent = 0;
    bit       gaps_on = 1'b1;

    wildcard_star_matcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),       // [7:0] symbol
        .s_axis_tuser  (s_tuser),       // [1:0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)   // [0] matched, [1] overflow, [7:2] zero
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // star positions may match empty: carry live bits across them
    function automatic logic [PATTERN_MAX:0] star_close(input logic [PATTERN_MAX:0] s);
        for (int i = 0; i < pat_len; i++)
            if (s[i] && pat_mem[i] == STAR_BYTE)
                s[i+1] = 1'b1;
        return s;
    endfunction

    function automatic void glob_apply(input mode_t m, input logic [7:0] sym);
        logic [PATTERN_MAX:0] cur;
        logic [PATTERN_MAX:0] nxt;
        verdict_t             v;
        case (m)
            MODE_CLEAR:
            begin
                pat_len = 0;
                dropped = 1'b0;
                live = (PATTERN_MAX + 1)'(1);
            end
            MODE_APPEND:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                else
                    dropped = 1'b1;
                live = (PATTERN_MAX + 1)'(1);
            end
            MODE_SUBJECT:
            begin
                cur = star_close(live);
                nxt = '0;
                for (int i = 0; i < pat_len; i++)
                begin
                    if (cur[i])
                    begin
                        if (pat_mem[i] == STAR_BYTE)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == sym)
                            nxt[i+1] = 1'b1;
                    end
                end
                live = nxt;
            end
            default:
            begin
                cur = star_close(live);
                v.matched = cur[pat_len];
                v.overflow = dropped;
                verdicts.push_back(v);
                live = (PATTERN_MAX + 1)'(1);
            end
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input mode_t m, input logic [7:0] sym);
        while (gaps_on && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sym;
        s_tuser <= m;
        do
            @(posedge clk);
        while (!s_axis_tready);
        glob_apply(m, sym);
        items_sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= gaps_on ? ($urandom_range(99) >= 20) : 1'b1;

    always @(posedge clk)
    begin
        verdict_t want;
        if (m_axis_tvalid && m_tready)
        begin
            if (verdicts.size() == 0)
            begin
                $error("unexpected result item: tdata %02h", m_axis_tdata);
                fails++;
            end
            else
            begin
                want = verdicts.pop_front();
                if (m_axis_tdata[0] !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, m_axis_tdata[0]);
                    fails++;
                end
                if (m_axis_tdata[1] !== want.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_axis_tdata[1]);
                    fails++;
                end
                if (m_axis_tdata[7:2] !== 6'd0)
                begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[7:2]);
                    fails++;
                end
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return 8'h61;
            4, 5: return 8'h62;
            6: return STAR_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_directed();
        send_item(MODE_END, 8'hAA);             // empty pattern, empty subject
        send_item(MODE_SUBJECT, 8'h00);
        send_item(MODE_END, 8'h00);             // empty pattern, nonempty subject
        send_item(MODE_APPEND, STAR_BYTE);
        send_item(MODE_APPEND, STAR_BYTE);
        send_item(MODE_END, 8'h00);             // only stars, exhausted subject
        send_item(MODE_CLEAR, 8'hFF);
        send_item(MODE_APPEND, 8'h00);
        send_item(MODE_APPEND, STAR_BYTE);
        send_item(MODE_APPEND, 8'hFF);
        send_item(MODE_SUBJECT, 8'h00);
        send_item(MODE_SUBJECT, 8'hFF);
        send_item(MODE_END, 8'hFF);
        send_item(MODE_SUBJECT, 8'h00);
        send_item(MODE_SUBJECT, STAR_BYTE);
        send_item(MODE_SUBJECT, 8'hFF);
        send_item(MODE_SUBJECT, 8'hFF);
        send_item(MODE_END, 8'h55);
        send_item(MODE_SUBJECT, 8'hFF);
        send_item(MODE_END, 8'h00);
        send_item(MODE_SUBJECT, 8'h00);
        send_item(MODE_APPEND, STAR_BYTE);      // append mid-subject restarts it
        send_item(MODE_SUBJECT, 8'h00);
        send_item(MODE_SUBJECT, 8'hFF);
        send_item(MODE_END, 8'h00);
    endtask

    task automatic test_store_full();
        send_item(MODE_CLEAR, 8'h00);
        repeat (PATTERN_MAX - 1) send_item(MODE_APPEND, 8'h41);
        send_item(MODE_APPEND, STAR_BYTE);
        repeat (PATTERN_MAX - 1) send_item(MODE_SUBJECT, 8'h41);
        send_item(MODE_END, 8'h00);
        send_item(MODE_APPEND, 8'h42);          // dropped
        repeat (PATTERN_MAX - 1) send_item(MODE_SUBJECT, 8'h41);
        send_item(MODE_SUBJECT, 8'h43);
        send_item(MODE_END, 8'h00);
        send_item(MODE_END, 8'h00);
        send_item(MODE_CLEAR, 8'h00);
        send_item(MODE_END, 8'h00);
    endtask

    task automatic test_random_globs(input int target);
        logic [7:0] pq [$];
        logic [7:0] b;
        int         k;
        int         plen;
        int         start;
        start = items_sent;
        while (items_sent < target)
        begin
            gaps_on = !(items_sent > start + 600 && items_sent < start + 1000);
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(mode_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(3) != 0)
                begin
                    send_item(MODE_CLEAR, 8'($urandom_range(255)));
                    pq.delete();
                end
                k = $urandom_range(99);
                plen = (k < 88) ? $urandom_range(0, 8) :
                       (k < 96) ? $urandom_range(9, 20) : $urandom_range(60, 70);
                repeat (plen)
                begin
                    b = ($urandom_range(2) == 0) ? STAR_BYTE : pick_byte();
                    send_item(MODE_APPEND, b);
                    pq.push_back(b);
                end
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        for (int j = 0; j < pq.size() && j < PATTERN_MAX; j++)
                        begin
                            if (pq[j] == STAR_BYTE)
                                repeat ($urandom_range(0, 3)) send_item(MODE_SUBJECT, pick_byte());
                            else
                                send_item(MODE_SUBJECT,
                                          ($urandom_range(15) == 0) ? pick_byte() : pq[j]);
                        end
                    end
                    else
                        repeat ($urandom_range(0, 10)) send_item(MODE_SUBJECT, pick_byte());
                    if ($urandom_range(19) == 0)
                    begin
                        b = pick_byte();
                        send_item(MODE_APPEND, b);
                        pq.push_back(b);
                    end
                    send_item(MODE_END, 8'($urandom_range(255)));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int guard;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_store_full();
        test_random_globs(items_sent + 1700);
        s_tvalid <= 1'b0;
        guard = 0;
        while (verdicts.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (verdicts.size() != 0)
        begin
            $error("%0d expected results never arrived", verdicts.size());
            fails++;
        end
        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
